// File: sv/ffha_pkg.sv
// Shared types, constants and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 4;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 30;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST     = 32'd0;
  localparam logic [ADDR_W-1:0] HEAP_CAPACITY_RST = 32'd65536;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_CAPACITY = 1'b1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SEND
  } state_t;

  typedef struct packed {
    logic start;
    logic walk;
    logic commit;
    logic send;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic walk_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/ffha_if.sv
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if;
  logic                                valid;
  logic                                ready;
  ffha_pkg::opcode_t                   opcode;
  logic [ffha_pkg::SIZE_W-1:0]         request_size;
  logic [ffha_pkg::ADDR_W-1:0]         release_address;

  modport source (output valid, output opcode, output request_size,
                  output release_address, input ready);
  modport sink (input valid, input opcode, input request_size,
                input release_address, output ready);
endinterface

interface ffha_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ffha_pkg::ADDR_W-1:0]         data_address;
  ffha_pkg::status_t                   status;
  logic [ffha_pkg::ADDR_W-1:0]         used_bytes;

  modport source (output valid, output data_address, output status,
                  output used_bytes, input ready);
  modport sink (input valid, input data_address, input status,
                input used_bytes, output ready);
endinterface

// File: sv/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ffha_datapath.sv
// Datapath: block table, heap registers, walk counters and result registers.
module ffha_datapath #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ffha_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ffha_pkg::opcode_t                  req_opcode,
  input  logic [ffha_pkg::SIZE_W-1:0]        req_size,
  input  logic [ffha_pkg::ADDR_W-1:0]        req_address,
  input  logic                               rsp_ready,
  output logic                               rsp_valid,
  output logic [ffha_pkg::ADDR_W-1:0]        rsp_data_address,
  output ffha_pkg::status_t                  rsp_status,
  output logic [ffha_pkg::ADDR_W-1:0]        rsp_used_bytes,
  input  ffha_pkg::ctrl_cmd_t                cmd,
  output ffha_pkg::ctrl_sts_t                sts
);

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int AW      = ffha_pkg::ADDR_W;
  localparam int SW      = ffha_pkg::SIZE_W;
  localparam int ENTRY_W = SW + 1;
  localparam logic [AW-1:0]    HDR     = AW'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [AW-1:0]       heap_base;
  logic [AW-1:0]       heap_capacity;
  logic [AW-1:0]       heap_top;
  logic [CNT_W-1:0]    block_count;
  ffha_pkg::opcode_t   op_q;
  logic [SW-1:0]       size_q;
  logic [AW-1:0]       addr_q;
  logic [CNT_W-1:0]    rd_idx;
  logic                ev_valid;
  logic [IDX_W-1:0]    ev_idx;
  logic [AW-1:0]       hdr;
  logic [AW-1:0]       res_addr;
  ffha_pkg::status_t   res_status;
  logic [AW-1:0]       res_used;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                q_free;
  logic [SW-1:0]       q_bytes;
  logic [AW-1:0]       blk_addr;
  logic                match;
  logic                hit;
  logic [AW+1:0]       new_end;
  logic                table_full;
  logic                no_mem;
  logic                append_ok;

  ffha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign q_free   = ram_rdata[SW];
  assign q_bytes  = ram_rdata[SW-1:0];
  assign blk_addr = heap_base + hdr + HDR;

  always_comb begin
    if (op_q == ffha_pkg::OP_ALLOC) begin
      match = q_free && (q_bytes >= size_q);
    end else begin
      match = (blk_addr == addr_q);
    end
  end

  assign hit        = ev_valid && match;
  assign new_end    = {2'b00, heap_top} + {2'b00, HDR} + {4'b0000, size_q};
  assign table_full = (block_count >= MAX_CNT);
  assign no_mem     = (new_end > {2'b00, heap_capacity});
  assign append_ok  = cmd.commit && !hit && (op_q == ffha_pkg::OP_ALLOC)
                      && !table_full && !no_mem;

  assign sts.hit       = hit;
  assign sts.walk_done = !ev_valid && (rd_idx >= block_count);
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    ram_we    = cmd.commit && (hit || append_ok);
    ram_waddr = hit ? ev_idx : block_count[IDX_W-1:0];
    ram_wdata = hit ? {op_q == ffha_pkg::OP_RELEASE, q_bytes} : {1'b0, size_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base     <= ffha_pkg::HEAP_BASE_RST;
      heap_capacity <= ffha_pkg::HEAP_CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ffha_pkg::CFG_HEAP_BASE:     heap_base <= cfg_data;
        ffha_pkg::CFG_HEAP_CAPACITY: heap_capacity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top    <= HDR;
      block_count <= ONE_CNT;
    end else if (append_ok) begin
      heap_top    <= new_end[AW-1:0];
      block_count <= block_count + ONE_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q   <= req_opcode;
      size_q <= req_size;
      addr_q <= req_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
      rd_idx   <= ONE_CNT;
    end else if (cmd.start) begin
      ev_valid <= 1'b0;
      rd_idx   <= ONE_CNT;
    end else if (cmd.walk) begin
      ev_valid <= (rd_idx < block_count);
      if (rd_idx < block_count) begin
        rd_idx <= rd_idx + ONE_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hdr <= HDR;
    end else if (cmd.walk && ev_valid && !match) begin
      hdr <= hdr + HDR + {2'b00, q_bytes};
    end
    if (cmd.walk) begin
      ev_idx <= rd_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_used <= append_ok ? new_end[AW-1:0] : heap_top;
      if (hit) begin
        res_status <= ffha_pkg::ST_OK;
        res_addr   <= (op_q == ffha_pkg::OP_ALLOC) ? blk_addr : '0;
      end else if (op_q == ffha_pkg::OP_RELEASE) begin
        res_status <= ffha_pkg::ST_UNKNOWN;
        res_addr   <= '0;
      end else if (table_full) begin
        res_status <= ffha_pkg::ST_FULL;
        res_addr   <= '0;
      end else if (no_mem) begin
        res_status <= ffha_pkg::ST_NOMEM;
        res_addr   <= '0;
      end else begin
        res_status <= ffha_pkg::ST_OK;
        res_addr   <= heap_base + heap_top + HDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.send) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      rsp_data_address <= res_addr;
      rsp_status       <= res_status;
      rsp_used_bytes   <= res_used;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (block_count >= ONE_CNT) && (block_count <= MAX_CNT))
    else $error("block count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (block_count != $past(block_count))
      |-> (block_count == $past(block_count) + ONE_CNT) && $past(append_ok))
    else $error("block count changed without an append");

  a_eval_index: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (ev_idx != '0) && ({1'b0, ev_idx} < {1'b0, block_count}))
    else $error("evaluated entry outside the live table");

  a_top_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(append_ok) |-> heap_top == $past(heap_top))
    else $error("heap top moved without an append");

endmodule

// File: sv/ffha_ctrl.sv
// Controller state machine sequencing accept, table walk, commit and send.
module ffha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ffha_pkg::ctrl_sts_t  sts,
  output ffha_pkg::ctrl_cmd_t  cmd
);

  ffha_pkg::state_t state;
  ffha_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ffha_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ffha_pkg::S_WALK;
        end
      end
      ffha_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.hit || sts.walk_done) begin
          cmd.commit = 1'b1;
          state_next = ffha_pkg::S_SEND;
        end
      end
      ffha_pkg::S_SEND: begin
        if (sts.out_free) begin
          cmd.send   = 1'b1;
          state_next = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffha_pkg::S_IDLE;
      end
    endcase
  end

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit && !req_ready)
    else $error("second commit or early accept after commit");

endmodule

// File: sv/first_fit_heap_allocator_core.sv
// First-fit heap allocator over a block table; accepts allocate and release requests,
// one result per request. Each request walks the block table through the table RAM's
// single read port at one entry per cycle; the walk ends early when an allocate reuses
// a free block or a release finds its block. The table needs no clearing after reset.
// Configuration writes (heap base, heap capacity) take effect at once and belong in
// idle periods. A finished response waits in an output register, so the next request
// is taken while the previous response is still pending.
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffha_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]   cfg_data,
  ffha_req_if.sink                          req,
  ffha_rsp_if.source                        rsp
);

  ffha_pkg::ctrl_cmd_t cmd;
  ffha_pkg::ctrl_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_opcode       (req.opcode),
    .req_size         (req.request_size),
    .req_address      (req.release_address),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_data_address (rsp.data_address),
    .rsp_status       (rsp.status),
    .rsp_used_bytes   (rsp.used_bytes),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
